[hw/rtl/apcs_pkg.sv]
// ---------------------------------------------------------------------------
// apcs_pkg
// Shared types and codes of the ATA PIO command sequencer: channel payloads,
// the job descriptor that runs from front end to back end, task-file codes.
// ---------------------------------------------------------------------------
`default_nettype none

package apcs_pkg;

   // sector geometry
   localparam int WORDS_PER_SECTOR = 256;
   localparam int WORD_INDEX_W     = $clog2(WORDS_PER_SECTOR);

   // job queue between front end and back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // input item kinds
   localparam logic [2:0] KIND_READ     = 3'd0;
   localparam logic [2:0] KIND_WRITE    = 3'd1;
   localparam logic [2:0] KIND_IDENTIFY = 3'd2;
   localparam logic [2:0] KIND_BUS_RESP = 3'd3;
   localparam logic [2:0] KIND_HOST     = 3'd4;

   // result kinds
   localparam logic [1:0] RK_BUS_READ  = 2'd0;
   localparam logic [1:0] RK_BUS_WRITE = 2'd1;
   localparam logic [1:0] RK_HOST_WORD = 2'd2;
   localparam logic [1:0] RK_DONE      = 2'd3;

   // task-file register indexes
   localparam logic [2:0] REG_DATA     = 3'd0;
   localparam logic [2:0] REG_COUNT    = 3'd2;
   localparam logic [2:0] REG_LBA_LOW  = 3'd3;
   localparam logic [2:0] REG_LBA_MID  = 3'd4;
   localparam logic [2:0] REG_LBA_HIGH = 3'd5;
   localparam logic [2:0] REG_DEVICE   = 3'd6;
   localparam logic [2:0] REG_STATUS   = 3'd7;
   localparam logic [2:0] REG_COMMAND  = 3'd7;

   // operations
   localparam logic [1:0] OP_READ     = 2'd0;
   localparam logic [1:0] OP_WRITE    = 2'd1;
   localparam logic [1:0] OP_IDENTIFY = 2'd2;

   // command bytes and status bits
   localparam logic [7:0] CMD_READ     = 8'h20;
   localparam logic [7:0] CMD_WRITE    = 8'h30;
   localparam logic [7:0] CMD_IDENTIFY = 8'hEC;
   localparam logic [7:0] DEVICE_LBA   = 8'h40;
   localparam int STATUS_BSY  = 7;
   localparam int STATUS_DRDY = 6;
   localparam int STATUS_DRQ  = 3;
   localparam int STATUS_ERR  = 0;

   // job codes
   localparam logic [2:0] JOB_STATUS = 3'd0;
   localparam logic [2:0] JOB_DATA   = 3'd1;
   localparam logic [2:0] JOB_HOST   = 3'd2;
   localparam logic [2:0] JOB_WDATA  = 3'd3;
   localparam logic [2:0] JOB_DONE   = 3'd4;
   localparam logic [2:0] JOB_IDENT  = 3'd5;
   localparam logic [2:0] JOB_SETUP  = 3'd6;

   // read that follows a data word
   localparam logic [1:0] TAIL_NONE   = 2'd0;
   localparam logic [1:0] TAIL_STATUS = 2'd1;
   localparam logic [1:0] TAIL_DATA   = 2'd2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [27:0] block_address;
      logic [7:0]  sector_count;
      logic [15:0] bus_read_value;
      logic [15:0] host_word_in;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [2:0]  register_index;
      logic [15:0] bus_write_value;
      logic [15:0] host_word_out;
      logic        error_flag;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  code;
      logic [1:0]  tail;
      logic [15:0] word;
      logic [27:0] address;
      logic [7:0]  count;
      logic        write_cmd;
      logic        error;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

[hw/rtl/ata_pio_command_sequencer_core.sv]
// ---------------------------------------------------------------------------
// ata_pio_command_sequencer_core
// ATA PIO LBA28 host sequencer: turns read, write and identify requests,
// bus read responses and host data words into task-file bus accesses,
// host data words and a done beat per request.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_valid / req_ready | apcs_pkg::req_type
//   rsp     | out       | rsp_valid / rsp_ready | apcs_pkg::rsp_type
//
// req_ready is high whenever the four-entry job queue has room, so one
// input beat can be taken every cycle, also while a result waits.
// the back end sends one result beat per cycle unless the output stalls:
// a request setup emits seven, identify setup three, a data word one or two,
// so output beats set the rate. a result passes the queue and output register.
// synchronous reset empties the queue and output stage and returns to idle.
// ---------------------------------------------------------------------------
`default_nettype none

module ata_pio_command_sequencer_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire apcs_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      apcs_pkg::rsp_type rsp_data
);

   apcs_pkg::queue_status_type queue_status;
   apcs_pkg::job_type          push_job;
   apcs_pkg::job_type          head_job;
   logic                       push;
   logic                       pop;

   apcs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .queue_status (queue_status),
      .push         (push),
      .push_job     (push_job)
   );

   apcs_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_job     (push_job),
      .pop          (pop),
      .head_job     (head_job),
      .queue_status (queue_status)
   );

   apcs_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_job     (head_job),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

`default_nettype wire

[hw/rtl/apcs_front.sv]
// ---------------------------------------------------------------------------
// apcs_front
// Front end: takes request, bus response and host word beats, runs the
// protocol state and hands one job per productive beat to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module apcs_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output      logic                       req_ready,
   input  wire apcs_pkg::req_type          req_data,
   input  wire apcs_pkg::queue_status_type queue_status,
   output      logic                       push,
   output      apcs_pkg::job_type          push_job
);

   localparam logic [3:0] PH_IDLE       = 4'd0;
   localparam logic [3:0] PH_BSY        = 4'd1;
   localparam logic [3:0] PH_DRDY       = 4'd2;
   localparam logic [3:0] PH_DRQ        = 4'd3;
   localparam logic [3:0] PH_RDATA      = 4'd4;
   localparam logic [3:0] PH_WDATA      = 4'd5;
   localparam logic [3:0] PH_DRAIN_ST   = 4'd6;
   localparam logic [3:0] PH_DRAIN_DATA = 4'd7;
   localparam logic [3:0] PH_ERRST      = 4'd8;

   localparam int WIW = apcs_pkg::WORD_INDEX_W;

   logic [3:0]     phase_ff, phase_in;
   logic [1:0]     operation_ff, operation_in;
   logic [27:0]    address_ff, address_in;
   logic [7:0]     count_ff, count_in;
   logic [7:0]     sector_ff, sector_in;
   logic [WIW-1:0] word_ff, word_in;

   logic           accept;
   logic           job_valid;
   logic [7:0]     st;
   logic           wrap;
   logic [WIW-1:0] word_next;
   logic [7:0]     sector_next;
   logic           all_done;
   logic [15:0]    read_word;

   assign req_ready = !queue_status.full;
   assign accept    = req_valid && req_ready;
   assign st        = req_data.bus_read_value[15:8];
   assign push      = accept && job_valid;

   // word and sector counting
   assign wrap        = (word_ff == WIW'(apcs_pkg::WORDS_PER_SECTOR - 1));
   assign word_next   = wrap ? '0 : word_ff + WIW'(1);
   assign sector_next = sector_ff + {7'd0, wrap};
   assign all_done    = (sector_next >= count_ff);

   // identify data comes byte-swapped
   assign read_word = (operation_ff == apcs_pkg::OP_IDENTIFY) ?
                      {req_data.bus_read_value[7:0], req_data.bus_read_value[15:8]} :
                      req_data.bus_read_value;

   always_comb begin
      phase_in     = phase_ff;
      operation_in = operation_ff;
      address_in   = address_ff;
      count_in     = count_ff;
      sector_in    = sector_ff;
      word_in      = word_ff;
      job_valid    = 1'b0;
      push_job           = '0;
      push_job.code      = apcs_pkg::JOB_STATUS;
      push_job.tail      = apcs_pkg::TAIL_NONE;
      push_job.address   = address_ff;
      push_job.count     = count_ff;
      push_job.write_cmd = (operation_ff == apcs_pkg::OP_WRITE);
      push_job.error     = st[apcs_pkg::STATUS_ERR];
      if (accept) begin
         unique case (req_data.kind)
            apcs_pkg::KIND_READ, apcs_pkg::KIND_WRITE, apcs_pkg::KIND_IDENTIFY: begin
               if (phase_ff == PH_IDLE) begin
                  operation_in = req_data.kind[1:0];
                  if (req_data.kind == apcs_pkg::KIND_IDENTIFY) begin
                     address_in = '0;
                     count_in   = 8'd1;
                  end else begin
                     address_in = req_data.block_address;
                     count_in   = req_data.sector_count;
                  end
                  sector_in = '0;
                  word_in   = '0;
                  phase_in  = PH_BSY;
                  job_valid = 1'b1;
               end
            end
            apcs_pkg::KIND_BUS_RESP: begin
               unique case (phase_ff)
                  PH_BSY: begin
                     if (!st[apcs_pkg::STATUS_BSY]) begin
                        phase_in = PH_DRDY;
                     end
                     job_valid = 1'b1;
                  end
                  PH_DRDY: begin
                     job_valid = 1'b1;
                     if (!st[apcs_pkg::STATUS_DRDY]) begin
                        push_job.code = apcs_pkg::JOB_STATUS;
                     end else if (operation_ff == apcs_pkg::OP_IDENTIFY) begin
                        push_job.code = apcs_pkg::JOB_IDENT;
                        phase_in      = PH_DRQ;
                     end else begin
                        push_job.code = apcs_pkg::JOB_SETUP;
                        if (operation_ff == apcs_pkg::OP_READ && count_ff == 8'd0) begin
                           phase_in = PH_DRAIN_ST;
                        end else begin
                           phase_in = PH_DRQ;
                        end
                     end
                  end
                  PH_DRQ: begin
                     if (!st[apcs_pkg::STATUS_DRQ]) begin
                        job_valid = 1'b1;
                     end else if (operation_ff == apcs_pkg::OP_WRITE) begin
                        if (count_ff == 8'd0) begin
                           phase_in  = PH_ERRST;
                           job_valid = 1'b1;
                        end else begin
                           phase_in = PH_WDATA;
                        end
                     end else begin
                        phase_in      = PH_RDATA;
                        job_valid     = 1'b1;
                        push_job.code = apcs_pkg::JOB_DATA;
                     end
                  end
                  PH_RDATA: begin
                     job_valid     = 1'b1;
                     push_job.code = apcs_pkg::JOB_HOST;
                     push_job.word = read_word;
                     word_in       = word_next;
                     sector_in     = sector_next;
                     if (all_done) begin
                        phase_in      = PH_DRAIN_ST;
                        push_job.tail = apcs_pkg::TAIL_STATUS;
                     end else if (wrap) begin
                        phase_in      = PH_DRQ;
                        push_job.tail = apcs_pkg::TAIL_STATUS;
                     end else begin
                        push_job.tail = apcs_pkg::TAIL_DATA;
                     end
                  end
                  PH_DRAIN_ST: begin
                     job_valid = 1'b1;
                     if (st[apcs_pkg::STATUS_DRQ]) begin
                        phase_in      = PH_DRAIN_DATA;
                        push_job.code = apcs_pkg::JOB_DATA;
                     end else begin
                        phase_in = PH_ERRST;
                     end
                  end
                  PH_DRAIN_DATA: begin
                     job_valid = 1'b1;
                     phase_in  = PH_DRAIN_ST;
                  end
                  PH_ERRST: begin
                     job_valid     = 1'b1;
                     push_job.code = apcs_pkg::JOB_DONE;
                     phase_in      = PH_IDLE;
                  end
                  default: begin
                     job_valid = 1'b0;
                  end
               endcase
            end
            apcs_pkg::KIND_HOST: begin
               if (phase_ff == PH_WDATA) begin
                  job_valid     = 1'b1;
                  push_job.code = apcs_pkg::JOB_WDATA;
                  push_job.word = req_data.host_word_in;
                  word_in       = word_next;
                  sector_in     = sector_next;
                  if (all_done) begin
                     phase_in      = PH_ERRST;
                     push_job.tail = apcs_pkg::TAIL_STATUS;
                  end
               end
            end
            default: begin
               job_valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         operation_ff <= apcs_pkg::OP_READ;
         address_ff   <= '0;
         count_ff     <= '0;
         sector_ff    <= '0;
         word_ff      <= '0;
      end else begin
         phase_ff     <= phase_in;
         operation_ff <= operation_in;
         address_ff   <= address_in;
         count_ff     <= count_in;
         sector_ff    <= sector_in;
         word_ff      <= word_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/apcs_queue.sv]
// ---------------------------------------------------------------------------
// apcs_queue
// Short job queue in flops between front end and back end.
// ---------------------------------------------------------------------------
`default_nettype none

module apcs_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire apcs_pkg::job_type          push_job,
   input  wire logic                       pop,
   output      apcs_pkg::job_type          head_job,
   output      apcs_pkg::queue_status_type queue_status
);

   localparam int PW = apcs_pkg::QUEUE_PTR_W;
   localparam int CW = apcs_pkg::QUEUE_CNT_W;

   apcs_pkg::job_type entry_ff [apcs_pkg::QUEUE_DEPTH];

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] fill_ff, fill_in;

   assign head_job           = entry_ff[rd_ptr_ff];
   assign queue_status.full  = (fill_ff == CW'(apcs_pkg::QUEUE_DEPTH));
   assign queue_status.empty = (fill_ff == '0);

   always_comb begin
      wr_ptr_in = push ? PW'(wr_ptr_ff + PW'(1)) : wr_ptr_ff;
      rd_ptr_in = pop ? PW'(rd_ptr_ff + PW'(1)) : rd_ptr_ff;
      fill_in   = fill_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/apcs_back.sv]
// ---------------------------------------------------------------------------
// apcs_back
// Back end: expands the job at the queue head into result beats, one per
// cycle unless the output stalls, into a registered output stage.
// ---------------------------------------------------------------------------
`default_nettype none

module apcs_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire apcs_pkg::job_type          head_job,
   input  wire apcs_pkg::queue_status_type queue_status,
   output      logic                       pop,
   output      logic                       rsp_valid,
   input  wire logic                       rsp_ready,
   output      apcs_pkg::rsp_type          rsp_data
);

   function automatic logic [2:0] beat_count(apcs_pkg::job_type j);
      logic [2:0] n;
      unique case (j.code)
         apcs_pkg::JOB_HOST, apcs_pkg::JOB_WDATA:
            n = (j.tail == apcs_pkg::TAIL_NONE) ? 3'd1 : 3'd2;
         apcs_pkg::JOB_IDENT: n = 3'd3;
         apcs_pkg::JOB_SETUP: n = 3'd7;
         default:             n = 3'd1;
      endcase
      return n;
   endfunction

   function automatic apcs_pkg::rsp_type make_beat(apcs_pkg::job_type j, logic [2:0] idx);
      apcs_pkg::rsp_type b;
      logic [2:0]        tail_reg;
      b        = '0;
      tail_reg = (j.tail == apcs_pkg::TAIL_DATA) ? apcs_pkg::REG_DATA : apcs_pkg::REG_STATUS;
      b.result_kind    = apcs_pkg::RK_BUS_READ;
      b.register_index = apcs_pkg::REG_STATUS;
      unique case (j.code)
         apcs_pkg::JOB_STATUS: begin
            b.register_index = apcs_pkg::REG_STATUS;
         end
         apcs_pkg::JOB_DATA: begin
            b.register_index = apcs_pkg::REG_DATA;
         end
         apcs_pkg::JOB_HOST: begin
            if (idx == 3'd0) begin
               b.result_kind    = apcs_pkg::RK_HOST_WORD;
               b.register_index = apcs_pkg::REG_DATA;
               b.host_word_out  = j.word;
            end else begin
               b.register_index = tail_reg;
            end
         end
         apcs_pkg::JOB_WDATA: begin
            if (idx == 3'd0) begin
               b.result_kind     = apcs_pkg::RK_BUS_WRITE;
               b.register_index  = apcs_pkg::REG_DATA;
               b.bus_write_value = j.word;
            end else begin
               b.register_index = tail_reg;
            end
         end
         apcs_pkg::JOB_DONE: begin
            b.result_kind    = apcs_pkg::RK_DONE;
            b.register_index = apcs_pkg::REG_DATA;
            b.error_flag     = j.error;
         end
         apcs_pkg::JOB_IDENT: begin
            if (idx == 3'd0) begin
               b.result_kind    = apcs_pkg::RK_BUS_WRITE;
               b.register_index = apcs_pkg::REG_DEVICE;
            end else if (idx == 3'd1) begin
               b.result_kind     = apcs_pkg::RK_BUS_WRITE;
               b.register_index  = apcs_pkg::REG_COMMAND;
               b.bus_write_value = {apcs_pkg::CMD_IDENTIFY, 8'h00};
            end
         end
         apcs_pkg::JOB_SETUP: begin
            b.result_kind = apcs_pkg::RK_BUS_WRITE;
            unique case (idx)
               3'd0: begin
                  b.register_index  = apcs_pkg::REG_COUNT;
                  b.bus_write_value = {j.count, 8'h00};
               end
               3'd1: begin
                  b.register_index  = apcs_pkg::REG_LBA_LOW;
                  b.bus_write_value = {j.address[7:0], 8'h00};
               end
               3'd2: begin
                  b.register_index  = apcs_pkg::REG_LBA_MID;
                  b.bus_write_value = {j.address[15:8], 8'h00};
               end
               3'd3: begin
                  b.register_index  = apcs_pkg::REG_LBA_HIGH;
                  b.bus_write_value = {j.address[23:16], 8'h00};
               end
               3'd4: begin
                  b.register_index  = apcs_pkg::REG_DEVICE;
                  b.bus_write_value = {apcs_pkg::DEVICE_LBA | {4'h0, j.address[27:24]}, 8'h00};
               end
               3'd5: begin
                  b.register_index  = apcs_pkg::REG_COMMAND;
                  b.bus_write_value = {(j.write_cmd ? apcs_pkg::CMD_WRITE :
                                        apcs_pkg::CMD_READ), 8'h00};
               end
               default: begin
                  // closing status read
                  b.result_kind    = apcs_pkg::RK_BUS_READ;
                  b.register_index = apcs_pkg::REG_STATUS;
               end
            endcase
         end
         default: begin
            b.register_index = apcs_pkg::REG_STATUS;
         end
      endcase
      if (b.result_kind != apcs_pkg::RK_BUS_READ) begin
         if (b.result_kind != apcs_pkg::RK_BUS_WRITE) begin
            b.register_index = apcs_pkg::REG_DATA;
         end
      end
      return b;
   endfunction

   logic              rsp_valid_ff, rsp_valid_in;
   apcs_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [2:0]        beat_ff, beat_in;
   logic              load;
   logic              final_beat;
   apcs_pkg::rsp_type beat_data;

   assign load       = !queue_status.empty && (!rsp_valid_ff || rsp_ready);
   assign final_beat = (beat_ff == beat_count(head_job) - 3'd1);
   assign pop        = load && final_beat;

   always_comb begin
      beat_data      = make_beat(head_job, beat_ff);
      beat_data.last = final_beat;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      beat_in        = beat_ff;
      if (load) begin
         rsp_data_in  = beat_data;
         rsp_valid_in = 1'b1;
         beat_in      = final_beat ? 3'd0 : beat_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         beat_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         beat_ff      <= beat_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

[hw/rtl/apcs_checker.sv]
// ---------------------------------------------------------------------------
// apcs_checker
// Port-level checks on the sequencer's result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module apcs_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire apcs_pkg::rsp_type rsp_data
);

   // a stalled beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // done always closes the results of its item
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == apcs_pkg::RK_DONE |-> rsp_data.last)
      else $error("done beat not marked last");

   a_write_value_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind != apcs_pkg::RK_BUS_WRITE
      |-> rsp_data.bus_write_value == 16'h0000 && !(rsp_data.result_kind != apcs_pkg::RK_DONE
          && rsp_data.error_flag))
      else $error("stray write value or error flag");

endmodule

bind ata_pio_command_sequencer_core apcs_checker u_apcs_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

[verif/tb_ata_pio_command_sequencer_core.sv]
// ---------------------------------------------------------------------------
// tb_ata_pio_command_sequencer_core
// Self-checking bench for the ATA PIO command sequencer. The bench plays the
// drive side: it answers status polls so that read, write and identify
// sequences run to their done beat. Noise items are mixed in, and both
// channels stall at random. A cycle-free model of the sequencer predicts
// every result beat, and each beat is checked against it field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_ata_pio_command_sequencer_core;
   import apcs_pkg::*;

   localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

   typedef enum logic [3:0] {
      SEQ_IDLE,
      SEQ_WAIT_BUSY,
      SEQ_WAIT_READY,
      SEQ_WAIT_DRQ,
      SEQ_READ_DATA,
      SEQ_WRITE_DATA,
      SEQ_DRAIN_STATUS,
      SEQ_DRAIN_DATA,
      SEQ_FINAL_STATUS
   } seq_phase_type;

   class sequencer_model;
      seq_phase_type phase;
      logic [1:0]    op;
      logic [27:0]   addr;
      logic [7:0]    cnt;
      logic [7:0]    sect;
      logic [8:0]    word;
      rsp_type       fresh[$];
      rsp_type       due[$];
      int            mismatches;

      function new();
         phase      = SEQ_IDLE;
         op         = OP_READ;
         addr       = '0;
         cnt        = '0;
         sect       = '0;
         word       = '0;
         mismatches = 0;
      endfunction

      function int pending();
         return due.size();
      endfunction

      function void due_beat(logic [1:0] k, logic [2:0] r, logic [15:0] wv,
                             logic [15:0] hw, logic e);
         rsp_type b;
         b.result_kind     = k;
         b.register_index  = r;
         b.bus_write_value = wv;
         b.host_word_out   = hw;
         b.error_flag      = e;
         b.last            = 1'b0;
         fresh.push_back(b);
      endfunction

      // true once every sector is done
      function bit next_word();
         word = word + 9'd1;
         if (word >= WORDS_PER_SECTOR) begin
            word = '0;
            sect = sect + 8'd1;
         end
         return sect >= cnt;
      endfunction

      function void take_item(req_type item);
         logic [7:0]  st;
         logic [15:0] bv;
         bv = item.bus_read_value;
         st = bv[15:8];
         fresh.delete();
         case (item.kind)
            KIND_READ, KIND_WRITE, KIND_IDENTIFY: begin
               if (phase == SEQ_IDLE) begin
                  op    = item.kind[1:0];
                  addr  = (item.kind == KIND_IDENTIFY) ? 28'h0 : item.block_address;
                  cnt   = (item.kind == KIND_IDENTIFY) ? 8'd1 : item.sector_count;
                  sect  = '0;
                  word  = '0;
                  phase = SEQ_WAIT_BUSY;
                  due_beat(RK_BUS_READ, REG_STATUS, 16'h0, 16'h0, 1'b0);
               end
            end
            KIND_BUS_RESP: begin
               case (phase)
                  SEQ_WAIT_BUSY: begin
                     if (!st[STATUS_BSY]) phase = SEQ_WAIT_READY;
                     due_beat(RK_BUS_READ, REG_STATUS, 16'h0, 16'h0, 1'b0);
                  end
                  SEQ_WAIT_READY: begin
                     if (!st[STATUS_DRDY]) begin
                        due_beat(RK_BUS_READ, REG_STATUS, 16'h0, 16'h0, 1'b0);
                     end else if (op == OP_IDENTIFY) begin
                        due_beat(RK_BUS_WRITE, REG_DEVICE, 16'h0, 16'h0, 1'b0);
                        due_beat(RK_BUS_WRITE, REG_COMMAND, {CMD_IDENTIFY, 8'h00},
                                 16'h0, 1'b0);
                        phase = SEQ_WAIT_DRQ;
                        due_beat(RK_BUS_READ, REG_STATUS, 16'h0, 16'h0, 1'b0);
                     end else begin
                        due_beat(RK_BUS_WRITE, REG_COUNT, {cnt, 8'h00}, 16'h0, 1'b0);
                        due_beat(RK_BUS_WRITE, REG_LBA_LOW, {addr[7:0], 8'h00},
                                 16'h0, 1'b0);
                        due_beat(RK_BUS_WRITE, REG_LBA_MID, {addr[15:8], 8'h00},
                                 16'h0, 1'b0);
                        due_beat(RK_BUS_WRITE, REG_LBA_HIGH, {addr[23:16], 8'h00},
                                 16'h0, 1'b0);
                        due_beat(RK_BUS_WRITE, REG_DEVICE,
                                 {DEVICE_LBA | {4'h0, addr[27:24]}, 8'h00}, 16'h0, 1'b0);
                        due_beat(RK_BUS_WRITE, REG_COMMAND,
                                 {(op == OP_WRITE) ? CMD_WRITE : CMD_READ, 8'h00},
                                 16'h0, 1'b0);
                        // a read of nothing skips the drq wait
                        phase = (op == OP_READ && cnt == 8'd0) ? SEQ_DRAIN_STATUS
                                                                : SEQ_WAIT_DRQ;
                        due_beat(RK_BUS_READ, REG_STATUS, 16'h0, 16'h0, 1'b0);
                     end
                  end
                  SEQ_WAIT_DRQ: begin
                     if (!st[STATUS_DRQ]) begin
                        due_beat(RK_BUS_READ, REG_STATUS, 16'h0, 16'h0, 1'b0);
                     end else if (op == OP_WRITE) begin
                        if (cnt == 8'd0) begin
                           phase = SEQ_FINAL_STATUS;
                           due_beat(RK_BUS_READ, REG_STATUS, 16'h0, 16'h0, 1'b0);
                        end else begin
                           phase = SEQ_WRITE_DATA;
                        end
                     end else begin
                        phase = SEQ_READ_DATA;
                        due_beat(RK_BUS_READ, REG_DATA, 16'h0, 16'h0, 1'b0);
                     end
                  end
                  SEQ_READ_DATA: begin
                     due_beat(RK_HOST_WORD, REG_DATA, 16'h0,
                              (op == OP_IDENTIFY) ? {bv[7:0], bv[15:8]} : bv, 1'b0);
                     if (next_word()) begin
                        phase = SEQ_DRAIN_STATUS;
                        due_beat(RK_BUS_READ, REG_STATUS, 16'h0, 16'h0, 1'b0);
                     end else if (word == 9'd0) begin
                        phase = SEQ_WAIT_DRQ;
                        due_beat(RK_BUS_READ, REG_STATUS, 16'h0, 16'h0, 1'b0);
                     end else begin
                        due_beat(RK_BUS_READ, REG_DATA, 16'h0, 16'h0, 1'b0);
                     end
                  end
                  SEQ_DRAIN_STATUS: begin
                     if (st[STATUS_DRQ]) begin
                        phase = SEQ_DRAIN_DATA;
                        due_beat(RK_BUS_READ, REG_DATA, 16'h0, 16'h0, 1'b0);
                     end else begin
                        phase = SEQ_FINAL_STATUS;
                        due_beat(RK_BUS_READ, REG_STATUS, 16'h0, 16'h0, 1'b0);
                     end
                  end
                  SEQ_DRAIN_DATA: begin
                     phase = SEQ_DRAIN_STATUS;
                     due_beat(RK_BUS_READ, REG_STATUS, 16'h0, 16'h0, 1'b0);
                  end
                  SEQ_FINAL_STATUS: begin
                     phase = SEQ_IDLE;
                     due_beat(RK_DONE, REG_DATA, 16'h0, 16'h0, st[STATUS_ERR]);
                  end
                  default: ;
               endcase
            end
            KIND_HOST: begin
               if (phase == SEQ_WRITE_DATA) begin
                  due_beat(RK_BUS_WRITE, REG_DATA, item.host_word_in, 16'h0, 1'b0);
                  if (next_word()) begin
                     phase = SEQ_FINAL_STATUS;
                     due_beat(RK_BUS_READ, REG_STATUS, 16'h0, 16'h0, 1'b0);
                  end
               end
            end
            default: ;
         endcase
         if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
         foreach (fresh[i]) due.push_back(fresh[i]);
      endfunction

      task report(string msg);
         if (mismatches < 40) $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task field_check(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
      endtask

      task match_beat(rsp_type got);
         rsp_type want;
         if (due.size() == 0) begin
            report($sformatf("result beat %h with nothing expected", got));
            return;
         end
         want = due.pop_front();
         field_check("result_kind", 16'(got.result_kind), 16'(want.result_kind));
         field_check("register_index", 16'(got.register_index), 16'(want.register_index));
         field_check("bus_write_value", got.bus_write_value, want.bus_write_value);
         field_check("host_word_out", got.host_word_out, want.host_word_out);
         field_check("error_flag", 16'(got.error_flag), 16'(want.error_flag));
         field_check("last", 16'(got.last), 16'(want.last));
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   sequencer_model seq_model;
   int             burst_left;
   int             sent_items;
   int             item_cap;
   bit             hold_request;
   int             hold_left;
   int             ready_mode;
   int             mode_left;

   ata_pio_command_sequencer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: stall pattern changes mode every so often; one long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = 400;
      end
      if (mode_left == 0) begin
         ready_mode = $urandom_range(3);
         mode_left  = $urandom_range(10, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (ready_mode)
            0, 1: rsp_ready <= 1'b1;
            2: rsp_ready <= $urandom_range(1);
            default: rsp_ready <= ($urandom_range(3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) seq_model.match_beat(rsp_data);
   end

   function automatic req_type rand_item(logic [2:0] kind);
      req_type r;
      r.kind           = kind;
      r.block_address  = 28'($urandom);
      r.sector_count   = 8'($urandom);
      r.bus_read_value = 16'($urandom);
      r.host_word_in   = 16'($urandom);
      return r;
   endfunction

   function automatic req_type item_of(logic [2:0] kind, logic [27:0] lba, logic [7:0] cnt,
                                       logic [15:0] bv, logic [15:0] hw);
      req_type r;
      r.kind           = kind;
      r.block_address  = lba;
      r.sector_count   = cnt;
      r.bus_read_value = bv;
      r.host_word_in   = hw;
      return r;
   endfunction

   function automatic req_type status_with(int bit_pos, bit value);
      req_type r;
      r = rand_item(KIND_BUS_RESP);
      r.bus_read_value[bit_pos + 8] = value;
      return r;
   endfunction

   // well-formed answer for whatever the sequencer is waiting on
   function automatic req_type next_step();
      case (seq_model.phase)
         SEQ_WAIT_BUSY:    return status_with(STATUS_BSY, $urandom_range(99) < 35);
         SEQ_WAIT_READY:   return status_with(STATUS_DRDY, $urandom_range(99) < 70);
         SEQ_WAIT_DRQ:     return status_with(STATUS_DRQ, $urandom_range(99) < 75);
         SEQ_DRAIN_STATUS: return status_with(STATUS_DRQ, $urandom_range(99) < 30);
         SEQ_WRITE_DATA:   return rand_item(KIND_HOST);
         default:          return rand_item(KIND_BUS_RESP);
      endcase
   endfunction

   function automatic req_type busy_noise();
      case ($urandom_range(2))
         0: return rand_item(3'(KIND_UNUSED_LO + $urandom_range(2)));
         1: return rand_item($urandom_range(1) ? KIND_WRITE
                                               : ($urandom_range(1) ? KIND_READ
                                                                    : KIND_IDENTIFY));
         default: return rand_item(seq_model.phase == SEQ_WRITE_DATA ? KIND_BUS_RESP
                                                                     : KIND_HOST);
      endcase
   endfunction

   function automatic req_type idle_noise();
      case ($urandom_range(2))
         0: return rand_item(3'(KIND_UNUSED_LO + $urandom_range(2)));
         1: return rand_item(KIND_BUS_RESP);
         default: return rand_item(KIND_HOST);
      endcase
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      seq_model.take_item(item);
      sent_items++;
   endtask

   task automatic quiet_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (seq_model.pending() != 0) @(posedge clock);
   endtask

   task automatic run_job(input logic [2:0] kind, input logic [27:0] lba,
                          input logic [7:0] cnt, input int noise_pct);
      req_type r;
      r = rand_item(kind);
      r.block_address = lba;
      r.sector_count  = cnt;
      send_item(r);
      while (seq_model.phase != SEQ_IDLE && sent_items < item_cap) begin
         if ($urandom_range(99) < noise_pct) begin
            send_item(busy_noise());
         end else begin
            send_item(next_step());
         end
      end
   endtask

   initial begin
      int jobs;
      bit ident_done;
      seq_model     = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      burst_left    = 0;
      sent_items    = 0;
      item_cap      = 1000000;
      hold_request  = 1'b0;
      hold_left     = 0;
      mode_left     = 0;
      ready_mode    = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ignored while idle
      send_item(item_of(KIND_BUS_RESP, 28'h0000000, 8'h00, 16'hFFFF, 16'h0000));
      send_item(item_of(KIND_HOST, 28'hFFFFFFF, 8'hFF, 16'h0000, 16'hFFFF));
      send_item(item_of(KIND_UNUSED_HI, 28'hFFFFFFF, 8'hFF, 16'hFFFF, 16'hFFFF));
      // read of zero sectors at the top address; drdy accepted with bsy still set
      send_item(item_of(KIND_READ, 28'hFFFFFFF, 8'h00, 16'h0000, 16'h0000));
      send_item(item_of(KIND_BUS_RESP, 28'h0000000, 8'h00, 16'h80FF, 16'h0000));
      send_item(item_of(KIND_IDENTIFY, 28'h0000000, 8'h00, 16'h0000, 16'h0000));
      send_item(item_of(KIND_BUS_RESP, 28'h0000000, 8'h00, 16'h0000, 16'h0000));
      send_item(item_of(KIND_BUS_RESP, 28'h0000000, 8'h00, 16'h8000, 16'h0000));
      send_item(item_of(KIND_UNUSED_LO, 28'h0000000, 8'h00, 16'h0000, 16'h0000));
      send_item(item_of(KIND_BUS_RESP, 28'h0000000, 8'h00, 16'hC000, 16'h0000));
      send_item(item_of(KIND_BUS_RESP, 28'h0000000, 8'h00, 16'h0000, 16'h0000));
      send_item(item_of(KIND_BUS_RESP, 28'h0000000, 8'h00, 16'h0155, 16'h0000));
      // write of zero sectors at address zero still waits for drq once
      send_item(item_of(KIND_WRITE, 28'h0000000, 8'h00, 16'hFFFF, 16'hFFFF));
      send_item(item_of(KIND_BUS_RESP, 28'h0000000, 8'h00, 16'h7FFF, 16'h0000));
      send_item(item_of(KIND_BUS_RESP, 28'h0000000, 8'h00, 16'hFF00, 16'h0000));
      send_item(item_of(KIND_BUS_RESP, 28'h0000000, 8'h00, 16'hF7FF, 16'h0000));
      send_item(item_of(KIND_HOST, 28'h0000000, 8'h00, 16'h0000, 16'hA5A5));
      send_item(item_of(KIND_BUS_RESP, 28'h0000000, 8'h00, 16'h0800, 16'h0000));
      send_item(item_of(KIND_BUS_RESP, 28'h0000000, 8'h00, 16'hFE00, 16'h0000));

      // random zero-count jobs, with one identify that moves a whole sector
      jobs       = 0;
      ident_done = 1'b0;
      while (sent_items < 320 || !ident_done || jobs < 9) begin
         if (jobs == 2) hold_request = 1'b1;
         if (jobs == 8) quiet_until_drained();
         if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) send_item(idle_noise());
         if (!ident_done && jobs >= 4) begin
            ident_done = 1'b1;
            run_job(KIND_IDENTIFY, 28'($urandom), 8'($urandom), 3);
         end else begin
            run_job($urandom_range(1) ? KIND_WRITE : KIND_READ, 28'($urandom), 8'h00, 12);
         end
         jobs++;
      end

      // long write at the top address, cut short once its data words flow
      item_cap = sent_items + 24;
      run_job(KIND_WRITE, 28'hFFFFFFF, 8'hFF, 3);

      quiet_until_drained();
      repeat (20) @(posedge clock);
      if (seq_model.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #100000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
